FILE: hdl/block_buffer_cache_table_macros.svh
// ----------------------------------------------------------------------------
// block_buffer_cache_table_macros
// assertion macros used by the bbct_checker file
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_TABLE_MACROS_SVH
`define BLOCK_BUFFER_CACHE_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBCT_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbct assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BBCT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbct assertion failed");

`endif

FILE: hdl/bbct_pkg.sv
// ----------------------------------------------------------------------------
// bbct_pkg
// types and constants of the block buffer cache table
// ----------------------------------------------------------------------------
package bbct_pkg;

	localparam int NUM_SLOTS = 32;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLOT_W    = 5;
	localparam int DEV_W     = 8;
	localparam int BLK_W     = 32;
	localparam int TAG_W     = DEV_W + BLK_W;
	localparam int REF_W     = 8;

	typedef enum logic [1:0] {
		OP_GET     = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_FREE    = 2'd1,
		ST_COUNT_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [DEV_W-1:0]  device;
		logic [BLK_W-1:0]  block_number;
		logic [SLOT_W-1:0] slot_in;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_out;
		logic              hit;
		logic              needs_fill;
		status_t           status;
	} rsp_t;

endpackage

FILE: hdl/bbct_ram.sv
// ----------------------------------------------------------------------------
// bbct_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bbct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/block_buffer_cache_table.sv
// get: tag memory scanned one slot per cycle; a miss strobes its result once the last
// slot is compared, a hit goes on through S_REF_RD and S_REF_WR to its result strobe
// release, pin, unpin: count read (S_REF_RD), written (S_REF_WR), result strobe
// one item at a time; busy is high from accept until the result strobe
// reset clears in-use and count-valid flags at once, no memory clearing pass
// ----------------------------------------------------------------------------
// block_buffer_cache_table
// buffer slot table with lookup by device and block, and reference counts
// ----------------------------------------------------------------------------
module block_buffer_cache_table
	import bbct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REF_RD,
		S_REF_WR
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
	localparam logic [REF_W-1:0] REF_MAX  = '1;
	localparam logic [REF_W-1:0] REF_ONE  = REF_W'(1);

	state_t               state_q;
	req_t                 req_q;
	logic                 in_range_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 issue_done_q;
	logic [IDX_W-1:0]     idx_s1;
	logic                 vld_s1;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [IDX_W-1:0]     target_q;
	logic [NUM_SLOTS-1:0] in_use_q;
	logic [NUM_SLOTS-1:0] refs_vld_q;
	logic                 done_q;
	rsp_t                 rsp_q;

	logic [TAG_W-1:0] tag_rdata;
	logic [REF_W-1:0] refs_rdata;

	logic             tag_match;
	logic             scan_last;
	logic             free_now;
	logic             free_any;
	logic [IDX_W-1:0] free_slot;
	logic             claim;
	logic [REF_W-1:0] ref_cur;
	logic [REF_W-1:0] ref_inc;
	logic [REF_W-1:0] ref_dec;
	logic             is_up;
	logic             upd;
	logic             refs_we;
	logic [IDX_W-1:0] refs_waddr;
	logic [REF_W-1:0] refs_wdata;

	always_comb begin
		tag_match  = vld_s1 && in_use_q[idx_s1]
			&& (tag_rdata == {req_q.device, req_q.block_number});
		scan_last  = vld_s1 && (idx_s1 == LAST_IDX);
		free_now   = vld_s1 && !in_use_q[idx_s1];
		free_any   = free_found_q || free_now;
		free_slot  = free_found_q ? free_idx_q : idx_s1;
		claim      = (state_q == S_SCAN) && scan_last && !tag_match && free_any;
		ref_cur    = refs_vld_q[target_q] ? refs_rdata : '0;
		ref_inc    = (ref_cur == REF_MAX) ? ref_cur : ref_cur + REF_ONE;
		ref_dec    = ref_cur - REF_ONE;
		is_up      = (req_q.op == OP_GET) || (req_q.op == OP_PIN);
		upd        = (state_q == S_REF_WR) && in_range_q && (is_up || (ref_cur != '0));
		refs_we    = claim || upd;
		refs_waddr = claim ? free_slot : target_q;
		refs_wdata = claim ? REF_ONE : (is_up ? ref_inc : ref_dec);
	end

	bbct_ram #(
		.WIDTH(TAG_W),
		.DEPTH(NUM_SLOTS)
	) u_tag_ram (
		.clk  (clk),
		.we   (claim),
		.waddr(free_slot),
		.wdata({req_q.device, req_q.block_number}),
		.raddr(idx_q),
		.rdata(tag_rdata)
	);

	bbct_ram #(
		.WIDTH(REF_W),
		.DEPTH(NUM_SLOTS)
	) u_refs_ram (
		.clk  (clk),
		.we   (refs_we),
		.waddr(refs_waddr),
		.wdata(refs_wdata),
		.raddr(target_q),
		.rdata(refs_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			in_range_q   <= 1'b0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			idx_s1       <= '0;
			vld_s1       <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			target_q     <= '0;
			in_use_q     <= '0;
			refs_vld_q   <= '0;
			done_q       <= 1'b0;
			rsp_q        <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q        <= req;
						in_range_q   <= (req.op == OP_GET)
							|| (9'(req.slot_in) < 9'(NUM_SLOTS));
						target_q     <= IDX_W'(req.slot_in);
						idx_q        <= '0;
						issue_done_q <= 1'b0;
						vld_s1       <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= (req.op == OP_GET) ? S_SCAN : S_REF_RD;
					end
				end
				S_SCAN: begin
					if (!issue_done_q) begin
						idx_s1 <= idx_q;
						vld_s1 <= 1'b1;
						if (idx_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end else begin
						vld_s1 <= 1'b0;
					end
					if (tag_match) begin
						target_q <= idx_s1;
						state_q  <= S_REF_RD;
					end else begin
						if (free_now && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
						if (scan_last) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (free_any) begin
								in_use_q[free_slot]   <= 1'b1;
								refs_vld_q[free_slot] <= 1'b1;
								rsp_q.slot_out        <= SLOT_W'(free_slot);
								rsp_q.hit             <= 1'b0;
								rsp_q.needs_fill      <= 1'b1;
								rsp_q.status          <= ST_OK;
							end else begin
								rsp_q.slot_out   <= '0;
								rsp_q.hit        <= 1'b0;
								rsp_q.needs_fill <= 1'b0;
								rsp_q.status     <= ST_NO_FREE;
							end
						end
					end
				end
				S_REF_RD: begin
					state_q <= S_REF_WR;
				end
				S_REF_WR: begin
					done_q           <= 1'b1;
					state_q          <= S_IDLE;
					rsp_q.slot_out   <= (req_q.op == OP_GET)
						? SLOT_W'(target_q) : req_q.slot_in;
					rsp_q.hit        <= (req_q.op == OP_GET);
					rsp_q.needs_fill <= 1'b0;
					rsp_q.status     <= (in_range_q && !is_up && (ref_cur == '0))
						? ST_COUNT_ZERO : ST_OK;
					if (upd) begin
						refs_vld_q[target_q] <= 1'b1;
						if ((req_q.op == OP_RELEASE) && (ref_cur == REF_ONE)) begin
							in_use_q[target_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hdl/bbct_checker.sv
// ----------------------------------------------------------------------------
// bbct_checker
// port-level checks of the block buffer cache table, bound to the top level
// ----------------------------------------------------------------------------
`include "block_buffer_cache_table_macros.svh"

module bbct_checker
	import bbct_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// an accepted beat always makes the block busy in the next cycle
	`BBCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// results only come out once the block has gone idle
	`BBCT_ASSERT_IMPL(a_done_idle, done, !busy)
	`BBCT_ASSERT_IMPL(a_busy_fall_done, $fell(busy), done)
	// a hit never needs a fill and never fails
	`BBCT_ASSERT_IMPL(a_hit_clean, done && rsp.hit, !rsp.needs_fill && rsp.status == ST_OK)
	`BBCT_ASSERT_IMPL(a_no_free_shape, done && rsp.status == ST_NO_FREE,
		rsp.slot_out == '0 && !rsp.hit && !rsp.needs_fill)

endmodule

bind block_buffer_cache_table bbct_checker u_bbct_checker (.*);

FILE: tb/block_buffer_cache_table_checker.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_table_checker
// watches request and result beats of the buffer cache table, keeps its own
// copy of the slot table, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module block_buffer_cache_table_checker
	import bbct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   errors,
	output int   outstanding,
	output int   checked,
	output int   hits,
	output int   refused
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	logic             in_use [NUM_SLOTS];
	logic [DEV_W-1:0] dev_tag [NUM_SLOTS];
	logic [BLK_W-1:0] blk_tag [NUM_SLOTS];
	logic [REF_W-1:0] refs [NUM_SLOTS];
	logic             filled [NUM_SLOTS];

	rsp_t pending_rsp[$];
	int   mismatches = 0;
	int   waiting = 0;
	int   compared = 0;
	int   hit_count = 0;
	int   refused_count = 0;

	assign errors      = mismatches;
	assign outstanding = waiting;
	assign checked     = compared;
	assign hits        = hit_count;
	assign refused     = refused_count;

	function automatic rsp_t table_response(input req_t r);
		rsp_t res;
		int   s;
		res = '{slot_out: r.slot_in, hit: 1'b0, needs_fill: 1'b0, status: ST_OK};
		s = int'(r.slot_in);
		if (r.op == OP_GET) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (in_use[i] && dev_tag[i] == r.device
					&& blk_tag[i] == r.block_number) begin
					res.slot_out   = SLOT_W'(i);
					res.hit        = 1'b1;
					res.needs_fill = !filled[i];
					if (refs[i] != '1)
						refs[i] = refs[i] + 1'b1;
					filled[i] = 1'b1;
					return res;
				end
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (!in_use[i]) begin
					in_use[i]      = 1'b1;
					dev_tag[i]     = r.device;
					blk_tag[i]     = r.block_number;
					refs[i]        = REF_W'(1);
					filled[i]      = 1'b1;
					res.slot_out   = SLOT_W'(i);
					res.needs_fill = 1'b1;
					return res;
				end
			end
			res.slot_out = '0;
			res.status   = ST_NO_FREE;
			return res;
		end
		if (s >= NUM_SLOTS)
			return res;
		if (r.op == OP_PIN) begin
			if (refs[s] != '1)
				refs[s] = refs[s] + 1'b1;
			return res;
		end
		if (refs[s] == '0) begin
			res.status = ST_COUNT_ZERO;
			return res;
		end
		refs[s] = refs[s] - 1'b1;
		if (r.op == OP_RELEASE && refs[s] == '0)
			in_use[s] = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				in_use[i] = 1'b0;
				refs[i]   = '0;
				filled[i] = 1'b0;
			end
			pending_rsp.delete();
		end else begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result beat with nothing expected: %s %0d %0d %0d %0d",
							$time, "slot/hit/fill/status", rsp.slot_out, rsp.hit,
							rsp.needs_fill, rsp.status);
				end else begin
					want = pending_rsp.pop_front();
					compared++;
					if (want.hit)
						hit_count++;
					if (want.status == ST_NO_FREE)
						refused_count++;
					if (rsp.slot_out !== want.slot_out || rsp.hit !== want.hit ||
						rsp.needs_fill !== want.needs_fill || rsp.status !== want.status) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: mismatch, expected slot %0d hit %0b fill %0b status %0d",
								$time, want.slot_out, want.hit, want.needs_fill, want.status);
							$display("%0t:           got slot %0d hit %0b fill %0b status %0d",
								$time, rsp.slot_out, rsp.hit, rsp.needs_fill, rsp.status);
						end
					end
				end
			end
			if (start && !busy)
				pending_rsp.push_back(table_response(req));
		end
		waiting = pending_rsp.size();
	end

endmodule

FILE: tb/block_buffer_cache_table_tb.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_table_tb
// drives get, release, pin and unpin requests into the buffer cache table:
// a directed opening, a count saturation run, then random traffic over a
// small tag pool with table fill bursts, under three sender idle settings
// ----------------------------------------------------------------------------
module block_buffer_cache_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbct_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 220;
	localparam int POOL_SIZE    = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	int errors;
	int outstanding;
	int checked;
	int hits;
	int refused;
	int idle_pct = 0;
	int sent = 0;

	logic [DEV_W-1:0] pool_dev [POOL_SIZE];
	logic [BLK_W-1:0] pool_blk [POOL_SIZE];

	always #2 clk = ~clk;

	block_buffer_cache_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	block_buffer_cache_table_checker table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.hits        (hits),
		.refused     (refused)
	);

	task automatic send(input req_t item);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic issue_get(input logic [DEV_W-1:0] d, input logic [BLK_W-1:0] b);
		req_t item;
		item.op           = OP_GET;
		item.device       = d;
		item.block_number = b;
		item.slot_in      = SLOT_W'($urandom);
		send(item);
	endtask

	task automatic issue_slot(input op_t o, input logic [SLOT_W-1:0] s);
		req_t item;
		item.op           = o;
		item.device       = DEV_W'($urandom);
		item.block_number = $urandom;
		item.slot_in      = s;
		send(item);
	endtask

	task automatic fill_table();
		repeat (NUM_SLOTS + 2)
			issue_get(DEV_W'($urandom), $urandom);
	endtask

	task automatic random_traffic();
		int pick;
		int k;
		pick = $urandom_range(99);
		if (pick < 3) begin
			fill_table();
		end else if (pick < 6) begin
			k = $urandom_range(NUM_SLOTS - 1);
			repeat ($urandom_range(4, 1))
				issue_slot(OP_RELEASE, SLOT_W'(k));
		end else if (pick < 40) begin
			k = $urandom_range(POOL_SIZE - 1);
			if ($urandom_range(99) < 8) begin
				pool_dev[k] = DEV_W'($urandom);
				pool_blk[k] = $urandom;
			end
			if ($urandom_range(99) < 85)
				issue_get(pool_dev[k], pool_blk[k]);
			else
				issue_get(DEV_W'($urandom), $urandom);
		end else if (pick < 72) begin
			issue_slot(OP_RELEASE, SLOT_W'($urandom_range(NUM_SLOTS - 1)));
		end else if (pick < 82) begin
			issue_slot(OP_PIN, SLOT_W'($urandom_range(NUM_SLOTS - 1)));
		end else begin
			issue_slot(OP_UNPIN, SLOT_W'($urandom_range(NUM_SLOTS - 1)));
		end
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("no beat accepted for %0d cycles", STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int phase_end;
		int idle_setting [3];
		idle_setting = '{36, 46, 0};
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_dev[i] = (i < 4) ? DEV_W'(i % 2) : DEV_W'($urandom);
			pool_blk[i] = (i < 4) ? BLK_W'(i / 2) : $urandom;
		end
		pool_dev[4] = '1;
		pool_blk[4] = '1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening sequence on a clean table
		issue_get(8'h00, 32'h0000_0000);
		issue_get(8'hff, 32'hffff_ffff);
		issue_get(8'h00, 32'h0000_0000);
		issue_get(8'hff, 32'h0000_0000);
		issue_get(8'h00, 32'hffff_ffff);
		issue_slot(OP_PIN, 5'd1);
		issue_slot(OP_UNPIN, 5'd1);
		issue_slot(OP_RELEASE, 5'd0);
		issue_slot(OP_RELEASE, 5'd0);
		issue_slot(OP_RELEASE, 5'd0);
		issue_slot(OP_UNPIN, 5'd0);
		issue_slot(OP_PIN, 5'd0);
		issue_get(8'h00, 32'h0000_0000);
		issue_slot(OP_UNPIN, 5'd31);
		issue_slot(OP_PIN, 5'd31);
		issue_slot(OP_RELEASE, 5'd31);
		issue_get(8'h5a, 32'ha5a5_5a5a);
		issue_get(8'h5a, 32'ha5a5_5a5a);
		issue_slot(OP_UNPIN, 5'd4);
		issue_get(8'h5a, 32'ha5a5_5a5a);

		// drive one slot count into saturation by hits and by pins
		repeat (256)
			issue_get(8'h5a, 32'ha5a5_5a5a);
		repeat (2)
			issue_slot(OP_PIN, 5'd4);
		issue_slot(OP_UNPIN, 5'd4);

		for (int p = 0; p < 3; p++) begin
			idle_pct  = idle_setting[p];
			phase_end = sent + RANDOM_ITEMS / 3;
			if (p == 0)
				fill_table();
			while (sent < phase_end)
				random_traffic();
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests driven under three sender idle settings, %0d results checked",
			sent, checked);
		$display("%0d gets hit a held block, %0d gets found the table full", hits, refused);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bbct_pkg.sv
hdl/bbct_ram.sv
hdl/block_buffer_cache_table.sv
hdl/bbct_checker.sv
tb/block_buffer_cache_table_checker.sv
tb/block_buffer_cache_table_tb.sv
